@@ hw/rtl/gf256_matrix_column_mix_top_assert.svh @@
// Assertion macros used by the column mixer top level.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef GF256_MATRIX_COLUMN_MIX_TOP_ASSERT_SVH
`define GF256_MATRIX_COLUMN_MIX_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GFMIX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gfmix assertion failed");

// Next-cycle implication, checked outside reset.
`define GFMIX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gfmix assertion failed");

`endif

@@ hw/rtl/gfmix_pkg.sv @@
package gfmix_pkg;

  localparam int unsigned NumBytes = 4;
  localparam int unsigned ByteBits = 8;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_COEF_ROW_0 = 3'd0,
    REG_COEF_ROW_1 = 3'd1,
    REG_COEF_ROW_2 = 3'd2,
    REG_COEF_ROW_3 = 3'd3,
    REG_REDUCTION  = 3'd4
  } cfg_reg_t;

  // Reset values give the standard AES MixColumns matrix.
  localparam logic [31:0] CoefRow0Reset  = 32'h0101_0302;
  localparam logic [31:0] CoefRow1Reset  = 32'h0103_0201;
  localparam logic [31:0] CoefRow2Reset  = 32'h0302_0101;
  localparam logic [31:0] CoefRow3Reset  = 32'h0201_0103;
  localparam logic [7:0]  ReductionReset = 8'h1B;

  typedef logic [NumBytes-1:0][ByteBits-1:0] col_t;

  // Four consecutive doublings of each column byte.
  typedef logic [NumBytes-1:0][3:0][ByteBits-1:0] pw4_t;

  // All eight doublings of each column byte.
  typedef logic [NumBytes-1:0][ByteBits-1:0][ByteBits-1:0] pw8_t;

  typedef struct packed {
    logic [NumBytes-1:0][31:0] coef;
    logic [ByteBits-1:0]       red;
  } cfg_t;

  // One doubling in the field: shift left and fold the overflow back in.
  function automatic logic [7:0] gf_double(input logic [7:0] x, input logic [7:0] red);
    logic [7:0] y;
    y = {x[6:0], 1'b0};
    if (x[7]) begin
      y = y ^ red;
    end
    return y;
  endfunction

endpackage

@@ hw/rtl/gfmix_cfg.sv @@
module gfmix_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output gfmix_pkg::cfg_t    cfg
);
  import gfmix_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coef[0] <= CoefRow0Reset;
      regs.coef[1] <= CoefRow1Reset;
      regs.coef[2] <= CoefRow2Reset;
      regs.coef[3] <= CoefRow3Reset;
      regs.red     <= ReductionReset;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_ROW_0: regs.coef[0] <= cfg_data;
        REG_COEF_ROW_1: regs.coef[1] <= cfg_data;
        REG_COEF_ROW_2: regs.coef[2] <= cfg_data;
        REG_COEF_ROW_3: regs.coef[3] <= cfg_data;
        REG_REDUCTION:  regs.red     <= cfg_data[7:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/gfmix_pwr.sv @@
module gfmix_pwr (
  input  gfmix_pkg::col_t    base,
  input  logic [7:0]         red,
  output gfmix_pkg::pw4_t    pw,
  output gfmix_pkg::col_t    nxt
);
  import gfmix_pkg::*;

  // Each byte yields base, 2*base, 4*base, 8*base and hands on 16*base.
  always_comb begin
    for (int k = 0; k < NumBytes; k++) begin
      pw[k][0] = base[k];
      for (int i = 1; i < 4; i++) begin
        pw[k][i] = gf_double(pw[k][i-1], red);
      end
      nxt[k] = gf_double(pw[k][3], red);
    end
  end

endmodule

@@ hw/rtl/gfmix_dot.sv @@
module gfmix_dot (
  input  gfmix_pkg::pw8_t    pw,
  input  gfmix_pkg::cfg_t    cfg,
  output gfmix_pkg::col_t    mixed
);
  import gfmix_pkg::*;

  // Each coefficient bit selects one doubling; the selected terms are XORed.
  always_comb begin
    for (int r = 0; r < NumBytes; r++) begin
      mixed[r] = '0;
      for (int k = 0; k < NumBytes; k++) begin
        for (int i = 0; i < ByteBits; i++) begin
          if (cfg.coef[r][ByteBits*k+i]) begin
            mixed[r] = mixed[r] ^ pw[k][i];
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/gf256_matrix_column_mix_top.sv @@
// Column mixer over GF(2^8). Each input word is one four-byte column; each
// output word is the column multiplied by a 4x4 coefficient matrix, where
// output byte r is the XOR of coef_row_r byte k times input byte k, and a
// product is built from repeated doublings reduced by reduction_byte. After
// reset the matrix and reduction byte give AES MixColumns. The block takes
// one word per clock while the output is not stalled and has three register
// stages between input accept and output valid: the first forms the first
// four doublings of every input byte, the second the last four, and the third
// (the output register) holds the selected and XORed dot products. Any stall
// on the output backs up through the stages without losing or repeating a
// word. Configuration writes are always accepted and must only be issued
// while no word is inside the pipeline.
module gf256_matrix_column_mix_top (
  input  logic        clk,
  input  logic        rst,
  // Input column.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // col_in_0, col_in_1, col_in_2, col_in_3
  // Mixed column.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // col_out_0, col_out_1, col_out_2, col_out_3
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gfmix_pkg::*;

  cfg_t cfg;

  // Stage one: low doublings plus the seed for the high doublings.
  logic v1;
  pw4_t s1_pw;
  col_t s1_base;
  // Stage two: all eight doublings of every byte.
  logic v2;
  pw8_t s2_pw;
  // Stage three: the output register.
  logic v3;
  col_t s3_out;

  logic ready1;
  logic ready2;
  logic ready3;

  col_t in_col;
  pw4_t lo_pw;
  col_t lo_nxt;
  pw4_t hi_pw;
  col_t hi_nxt;
  col_t mixed;

  gfmix_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A stage can load when it is empty or its contents move on this cycle.
  assign ready3 = !v3 || m_axis_tready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  assign s_axis_tready = ready1;
  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = s3_out;
  assign in_col        = s_axis_tdata;

  gfmix_pwr u_pwr_lo (
    .base (in_col),
    .red  (cfg.red),
    .pw   (lo_pw),
    .nxt  (lo_nxt)
  );

  // The sixteenfold value out of the high half is not needed.
  gfmix_pwr u_pwr_hi (
    .base (s1_base),
    .red  (cfg.red),
    .pw   (hi_pw),
    .nxt  (hi_nxt)
  );

  gfmix_dot u_dot (
    .pw    (s2_pw),
    .cfg   (cfg),
    .mixed (mixed)
  );

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= s_axis_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  // Payload registers load only when a word actually moves in.
  always_ff @(posedge clk) begin
    if (ready1 && s_axis_tvalid) begin
      s1_pw   <= lo_pw;
      s1_base <= lo_nxt;
    end
    if (ready2 && v1) begin
      for (int k = 0; k < NumBytes; k++) begin
        s2_pw[k] <= {hi_pw[k], s1_pw[k]};
      end
    end
    if (ready3 && v2) begin
      s3_out <= mixed;
    end
  end

`include "gf256_matrix_column_mix_top_assert.svh"

  // An accepted word always lands in the first stage.
  `GFMIX_ASSERT_NEXT(a_in_lands, s_axis_tvalid && s_axis_tready, v1)
  // A word leaving the first stage lands in the second.
  `GFMIX_ASSERT_NEXT(a_s1_moves, v1 && ready2, v2)
  // A stalled middle stage keeps its doublings.
  `GFMIX_ASSERT_NEXT(a_s2_holds, v2 && !ready3, v2 && $stable(s2_pw))
  // A word left in the output stage is never dropped while a new one waits.
  `GFMIX_ASSERT_NOW(a_no_overrun, v3 && !m_axis_tready, !ready3)

endmodule
